FILE: design/acat_pkg.sv
// Shared types and constants for the ARP cache with aging.
package acat_pkg;

  localparam int OP_W      = 2;
  localparam int IP_W      = 32;
  localparam int MAC_W     = 48;
  localparam int STAMP_W   = 32;
  localparam int SLOT_W    = 6;
  localparam int TMO_W     = 16;
  localparam logic [TMO_W-1:0] TMO_RST = 16'd15;

  // Operation codes as they arrive on the opcode port
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  // One queued command word
  typedef struct packed {
    opcode_t          op;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } cmd_t;

  // One table entry as held in the RAM
  typedef struct packed {
    logic               vld;
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // One result word
  typedef struct packed {
    logic              success;
    logic [MAC_W-1:0]  mac;
    logic [SLOT_W-1:0] slot;
  } res_t;

  // Table engine states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } eng_state_t;

endpackage

FILE: design/acat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module acat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/acat_front.sv
// Command front end: two-deep queue that takes and decodes incoming words.
module acat_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [acat_pkg::OP_W-1:0]   opcode,
  input  logic [acat_pkg::IP_W-1:0]   ip_address,
  input  logic [acat_pkg::MAC_W-1:0]  mac_address,
  output acat_pkg::cmd_t              cmd,
  output logic                        cmd_valid,
  input  logic                        cmd_take
);
  import acat_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  cmd_t       cmd_in;

  // decode the incoming word into a command
  always_comb begin
    cmd_in.op  = opcode_t'(opcode);
    cmd_in.ip  = ip_address;
    cmd_in.mac = mac_address;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;
  assign cmd       = slots[rd_ptr];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

endmodule

FILE: design/acat_engine.sv
// Table engine: scans the entry RAM once per command and forms the result.
module acat_engine #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  acat_pkg::cmd_t              cmd,
  input  logic                        cmd_valid,
  output logic                        cmd_take,
  input  logic [acat_pkg::TMO_W-1:0]  timeout,
  output acat_pkg::res_t              res,
  output logic                        res_valid,
  input  logic                        pop
);
  import acat_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int XW = AW + SLOT_W;
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  eng_state_t          state;
  eng_state_t          state_next;
  logic [AW-1:0]       cnt;
  logic                cnt_last;
  logic                rd_vld_q;
  logic [AW-1:0]       rd_addr_q;
  logic [STAMP_W-1:0]  seconds_now;
  opcode_t             op_q;
  logic [IP_W-1:0]     ip_q;
  logic [MAC_W-1:0]    mac_q;

  // scan accumulators
  logic                hit;
  logic                hit_next;
  logic [MAC_W-1:0]    hit_mac;
  logic [MAC_W-1:0]    hit_mac_next;
  logic [AW-1:0]       hit_idx;
  logic [AW-1:0]       hit_idx_next;
  logic                free;
  logic                free_next;
  logic [AW-1:0]       free_idx;
  logic [AW-1:0]       free_idx_next;
  logic                stale;
  logic [STAMP_W-1:0]  age;
  res_t                res_next;
  logic [XW-1:0]       slot_wide;

  // RAM side
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  entry_t              ram_wdata;
  logic                ram_re;
  entry_t              rd_entry;
  logic                res_load;

  acat_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt),
    .rdata (rd_entry)
  );

  assign cnt_last = (cnt == LAST);
  assign age      = seconds_now - rd_entry.stamp;

  // per-entry checks on the word read back
  always_comb begin
    hit_next      = hit;
    hit_mac_next  = hit_mac;
    hit_idx_next  = hit_idx;
    free_next     = free;
    free_idx_next = free_idx;
    stale         = 1'b0;
    if (rd_vld_q) begin
      case (op_q)
        OP_LOOKUP: begin
          if (rd_entry.vld && (rd_entry.ip == ip_q)) begin
            hit_next     = 1'b1;
            hit_mac_next = rd_entry.mac;
            hit_idx_next = rd_addr_q;
          end
        end
        OP_INSERT: begin
          if (!rd_entry.vld && !free) begin
            free_next     = 1'b1;
            free_idx_next = rd_addr_q;
          end
        end
        OP_TICK: begin
          stale = rd_entry.vld && (age > {{(STAMP_W-TMO_W){1'b0}}, timeout});
        end
        default: begin
          stale = 1'b0;
        end
      endcase
    end
  end

  // result word
  always_comb begin
    res_next  = '0;
    slot_wide = '0;
    case (op_q)
      OP_LOOKUP: begin
        if (hit_next) begin
          slot_wide        = XW'(hit_idx_next);
          res_next.success = 1'b1;
          res_next.mac     = hit_mac_next;
          res_next.slot    = slot_wide[SLOT_W-1:0];
        end
      end
      OP_INSERT: begin
        if (free_next) begin
          slot_wide        = XW'(free_idx_next);
          res_next.success = 1'b1;
          res_next.slot    = slot_wide[SLOT_W-1:0];
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  // next state; the end of a scan waits until the result register is free
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (cnt_last) state_next = ST_IDLE;
      ST_IDLE:  if (cmd_take) state_next = ST_SCAN;
      ST_SCAN:  if (cnt_last) state_next = ST_DONE;
      ST_DONE:  if (!res_valid || pop) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_addr_q;
    ram_wdata = rd_entry;
    ram_wdata.vld = 1'b0;
    ram_re    = 1'b0;
    cmd_take  = 1'b0;
    res_load  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        cmd_take = cmd_valid;
      end
      ST_SCAN: begin
        ram_re = 1'b1;
        ram_we = stale;
      end
      ST_DONE: begin
        res_load = !res_valid || pop;
        if (stale) begin
          ram_we = 1'b1;
        end else if ((op_q == OP_INSERT) && free_next) begin
          ram_we          = 1'b1;
          ram_waddr       = free_idx_next;
          ram_wdata.vld   = 1'b1;
          ram_wdata.ip    = ip_q;
          ram_wdata.mac   = mac_q;
          ram_wdata.stamp = seconds_now;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cnt         <= '0;
      rd_vld_q    <= 1'b0;
      seconds_now <= '0;
      res_valid   <= 1'b0;
      hit         <= 1'b0;
      free        <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld_q <= (state == ST_SCAN);
      if ((state == ST_CLEAR) || (state == ST_SCAN)) begin
        cnt <= cnt_last ? '0 : cnt + AW'(1);
      end
      if (cmd_take) begin
        hit  <= 1'b0;
        free <= 1'b0;
        if (cmd.op == OP_TICK) begin
          seconds_now <= seconds_now + STAMP_W'(1);
        end
      end else begin
        hit  <= hit_next;
        free <= free_next;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_addr_q <= cnt;
    hit_mac   <= hit_mac_next;
    hit_idx   <= hit_idx_next;
    free_idx  <= free_idx_next;
    if (cmd_take) begin
      op_q  <= cmd.op;
      ip_q  <= cmd.ip;
      mac_q <= cmd.mac;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  // no command leaves the queue during the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !cmd_take)
    else $error("command taken during clearing pass");

  // a result is only loaded when the result slot is free
  assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_valid || pop))
    else $error("result loaded over a waiting word");

  // a result appears only at the end of a scan
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside end of scan");

  // mid-scan writes only age out entries
  assert property (@(posedge clk) disable iff (rst)
    (ram_we && (state == ST_SCAN)) |-> (op_q == OP_TICK))
    else $error("table written mid-scan by a non-tick command");

endmodule

FILE: design/arp_cache_table_with_aging.sv
// Top level of the ARP cache with aging: command queue, table engine, timeout register.
//
// Each command (lookup, insert or one-second tick) reads every entry of the table once
// through the single read port of the entry RAM, one entry per clock, and goes from a
// start step through the scan to a closing step in which an insert is written and the
// result is loaded. Commands queue up to two deep in front of the engine, and a
// finished result waits on the result ports until popped while the next command
// already runs; that command then holds in its closing step until the result ports
// are free. After reset the engine clears the valid marks with a pass over every
// entry before the first command starts; commands may be pushed meanwhile. The
// timeout register is written through the cfg channel, which is always ready, and
// should only be changed while no command is outstanding.
module arp_cache_table_with_aging #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [acat_pkg::OP_W-1:0]   opcode,
  input  logic [acat_pkg::IP_W-1:0]   ip_address,
  input  logic [acat_pkg::MAC_W-1:0]  mac_address,
  output logic                        empty,
  input  logic                        pop,
  output logic                        success,
  output logic [acat_pkg::MAC_W-1:0]  mac_result,
  output logic [acat_pkg::SLOT_W-1:0] slot_index,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [acat_pkg::TMO_W-1:0]  cfg_data
);
  import acat_pkg::*;

  cmd_t             cmd;
  logic             cmd_valid;
  logic             cmd_take;
  res_t             res;
  logic             res_valid;
  logic [TMO_W-1:0] timeout_seconds;

  // timeout register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= TMO_RST;
    end else if (cfg_valid && cfg_ready) begin
      timeout_seconds <= cfg_data;
    end
  end

  acat_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .ip_address  (ip_address),
    .mac_address (mac_address),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_take    (cmd_take)
  );

  acat_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .timeout   (timeout_seconds),
    .res       (res),
    .res_valid (res_valid),
    .pop       (pop)
  );

  // result word out
  assign empty      = !res_valid;
  assign success    = res.success;
  assign mac_result = res.mac;
  assign slot_index = res.slot;

endmodule
